/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define STC_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Check a consequence in the cycle after its trigger.
`define STC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/stc_pkg.sv */
// ----------------------------------------------------------------------------
// Source tokenizer package
// Token codes, scan modes, keyword table and shared record types.
// ----------------------------------------------------------------------------
package stc_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_P_EQ,
    MODE_P_BANG,
    MODE_P_LT,
    MODE_P_GT
  } scan_mode_t;

  localparam logic [5:0] K_NUMBER  = 6'd0;
  localparam logic [5:0] K_STRING  = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_LPAREN  = 6'd22;
  localparam logic [5:0] K_RPAREN  = 6'd23;
  localparam logic [5:0] K_COMMA   = 6'd24;
  localparam logic [5:0] K_SEMI    = 6'd25;
  localparam logic [5:0] K_SLASH   = 6'd26;
  localparam logic [5:0] K_PLUS    = 6'd27;
  localparam logic [5:0] K_MINUS   = 6'd28;
  localparam logic [5:0] K_STAR    = 6'd29;
  localparam logic [5:0] K_PERCENT = 6'd30;
  localparam logic [5:0] K_EQ      = 6'd31;
  localparam logic [5:0] K_EQEQ    = 6'd32;
  localparam logic [5:0] K_BANGEQ  = 6'd33;
  localparam logic [5:0] K_LT      = 6'd34;
  localparam logic [5:0] K_LTE     = 6'd35;
  localparam logic [5:0] K_GT      = 6'd36;
  localparam logic [5:0] K_GTE     = 6'd37;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_ERROR   = 6'd39;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_UNTERM = 2'd1;
  localparam logic [1:0] ERR_BANG   = 2'd2;
  localparam logic [1:0] ERR_CHAR   = 2'd3;

  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  localparam int KW_COUNT   = 19;
  localparam int KW_MAX_LEN = 9;

  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "start", "module", "modul", "lib", "print", "var", "func", "return", "end",
    "if", "else", "while", "for", "to", "and", "or", "not", "asm", {"input_", "int"}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd6, 4'd5, 4'd3, 4'd5, 4'd3, 4'd4, 4'd6, 4'd3,
    4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd9
  };

  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21
  };

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [31:0] start_pos;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic [62:0] number_value;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room;
  } fifo_status_t;

  typedef struct packed {
    logic idle;
    logic at_origin;
  } scan_status_t;

  function automatic token_t make_token(
    input logic [5:0]  kind,
    input logic [1:0]  err,
    input logic [31:0] start,
    input logic [15:0] len,
    input logic [23:0] line,
    input logic [62:0] num
  );
    token_t t;
    t.token_kind   = kind;
    t.error_kind   = err;
    t.start_pos    = start;
    t.token_length = len;
    t.line_number  = line;
    t.number_value = num;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

/* design/stc_channels.sv */
// ----------------------------------------------------------------------------
// Tokenizer channels
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface stc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source(output valid, output char_byte, output end_of_input, input ready);
  modport sink(input valid, input char_byte, input end_of_input, output ready);
endinterface

interface stc_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [31:0] start_pos;
  logic [15:0] token_length;
  logic [23:0] line_number;
  logic [62:0] number_value;
  logic        last_of_run;

  modport source(
    output valid, output token_kind, output error_kind, output start_pos,
    output token_length, output line_number, output number_value,
    output last_of_run, input ready
  );
  modport sink(
    input valid, input token_kind, input error_kind, input start_pos,
    input token_length, input line_number, input number_value,
    input last_of_run, output ready
  );
endinterface

/* design/stc_result_fifo.sv */
// ----------------------------------------------------------------------------
// Token result queue
// Small queue that takes up to two tokens per cycle and releases one.
// ----------------------------------------------------------------------------
module stc_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_count,
  input  stc_pkg::token_t       push0,
  input  stc_pkg::token_t       push1,
  input  logic                  pop,
  output stc_pkg::token_t       head,
  output stc_pkg::fifo_status_t status
);

  localparam int PtrW = $clog2(stc_pkg::FIFO_DEPTH);
  localparam int CntW = stc_pkg::FIFO_CNT_W;

  stc_pkg::token_t  entries [stc_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CntW'(push_count) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + PtrW'(1)] <= push1;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.room  = count <= CntW'(stc_pkg::FIFO_DEPTH - 2);

endmodule

/* design/stc_scanner.sv */
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Scan state and the per-byte step that yields up to two tokens.
// ----------------------------------------------------------------------------
module stc_scanner #(
  parameter int KEYWORD_CHARS = 9,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  commit,
  input  logic [7:0]            char_byte,
  input  logic                  end_of_input,
  output logic [1:0]            res_count,
  output stc_pkg::token_t       res0,
  output stc_pkg::token_t       res1,
  output stc_pkg::scan_status_t status
);

  localparam int PosExtW = POSITION_BITS > 32 ? POSITION_BITS : 32;

  stc_pkg::scan_mode_t      scan_mode, scan_mode_next;
  logic [POSITION_BITS-1:0] token_start, token_start_next;
  logic [15:0]              token_count_len, token_count_len_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [23:0]              line_count, line_count_next;
  logic [62:0]              number_accum, number_accum_next;
  logic [7:0]               keyword_chars [KEYWORD_CHARS];

  logic                     kw_we;
  logic [15:0]              kw_wpos;
  logic [KEYWORD_CHARS-1:0] kw_sel;
  logic [stc_pkg::KW_COUNT-1:0] kw_hit;
  logic [5:0]               ident_kind;

  logic                     is_end, ch_letter, ch_numeral, consumed;
  logic [PosExtW-1:0]       tstart_ext, pos_ext;
  logic [15:0]              len_inc;
  logic [23:0]              line_inc;
  logic [66:0]              num_prod;
  logic [62:0]              num_sat;
  logic                     p_valid, i_valid;
  stc_pkg::token_t          p_tok, i_tok;
  logic [5:0]               one_kind;

  for (genvar e = 0; e < stc_pkg::KW_COUNT; e++) begin : g_kw
    localparam int Len = int'(stc_pkg::KW_LEN[e]);
    logic [stc_pkg::KW_MAX_LEN-1:0] ch_eq;
    for (genvar j = 0; j < stc_pkg::KW_MAX_LEN; j++) begin : g_ch
      if (j < Len) begin : g_cmp
        assign ch_eq[j] = keyword_chars[j] == stc_pkg::KW_TEXT[e][(Len-1-j)*8 +: 8];
      end else begin : g_pad
        assign ch_eq[j] = 1'b1;
      end
    end
    assign kw_hit[e] = (token_count_len == 16'(Len)) && (&ch_eq);
  end

  always_comb begin
    ident_kind = stc_pkg::K_IDENT;
    for (int e = 0; e < stc_pkg::KW_COUNT; e++) begin
      if (kw_hit[e]) begin
        ident_kind = stc_pkg::KW_KIND[e];
      end
    end
  end

  assign is_end     = end_of_input || (char_byte == 8'h00);
  assign ch_letter  = (char_byte >= "A" && char_byte <= "Z") ||
                      (char_byte >= "a" && char_byte <= "z") || (char_byte == "_");
  assign ch_numeral = char_byte >= "0" && char_byte <= "9";
  assign tstart_ext = PosExtW'(token_start);
  assign pos_ext    = PosExtW'(byte_position);
  assign len_inc    = (token_count_len == stc_pkg::LEN_MAX) ? token_count_len
                                                            : token_count_len + 16'd1;
  assign line_inc   = (line_count == stc_pkg::LINE_MAX) ? line_count : line_count + 24'd1;
  assign num_prod   = ({4'b0, number_accum} << 3) + ({4'b0, number_accum} << 1) +
                      67'(char_byte[3:0]);
  assign num_sat    = (num_prod[66:63] != 4'd0) ? {63{1'b1}} : num_prod[62:0];

  always_comb begin
    scan_mode_next       = scan_mode;
    token_start_next     = token_start;
    token_count_len_next = token_count_len;
    byte_position_next   = byte_position + POSITION_BITS'(1);
    line_count_next      = line_count;
    number_accum_next    = number_accum;
    kw_we                = 1'b0;
    kw_wpos              = token_count_len;
    consumed             = 1'b0;
    p_valid              = 1'b0;
    i_valid              = 1'b0;
    p_tok                = '0;
    i_tok                = '0;
    one_kind             = stc_pkg::K_ERROR;

    case (scan_mode)
      stc_pkg::MODE_COMMENT: begin
        if (!is_end && char_byte != "\n") begin
          consumed = 1'b1;
        end else begin
          scan_mode_next = stc_pkg::MODE_IDLE;
        end
      end
      stc_pkg::MODE_IDENT: begin
        if (!is_end && (ch_letter || ch_numeral)) begin
          kw_we                = 1'b1;
          token_count_len_next = len_inc;
          consumed             = 1'b1;
        end else begin
          p_valid        = 1'b1;
          p_tok          = stc_pkg::make_token(ident_kind, stc_pkg::ERR_NONE,
                             tstart_ext[31:0], token_count_len, line_count, '0);
          scan_mode_next = stc_pkg::MODE_IDLE;
        end
      end
      stc_pkg::MODE_NUMBER: begin
        if (!is_end && ch_numeral) begin
          number_accum_next    = num_sat;
          token_count_len_next = len_inc;
          consumed             = 1'b1;
        end else begin
          p_valid        = 1'b1;
          p_tok          = stc_pkg::make_token(stc_pkg::K_NUMBER, stc_pkg::ERR_NONE,
                             tstart_ext[31:0], token_count_len, line_count, number_accum);
          scan_mode_next = stc_pkg::MODE_IDLE;
        end
      end
      stc_pkg::MODE_STRING: begin
        if (is_end) begin
          p_valid        = 1'b1;
          p_tok          = stc_pkg::make_token(stc_pkg::K_ERROR, stc_pkg::ERR_UNTERM,
                             tstart_ext[31:0], token_count_len, line_count, '0);
          scan_mode_next = stc_pkg::MODE_IDLE;
        end else if (char_byte == "\"") begin
          p_valid        = 1'b1;
          p_tok          = stc_pkg::make_token(stc_pkg::K_STRING, stc_pkg::ERR_NONE,
                             tstart_ext[31:0], token_count_len, line_count, '0);
          scan_mode_next = stc_pkg::MODE_IDLE;
          consumed       = 1'b1;
        end else begin
          if (char_byte == "\n") begin
            line_count_next = line_inc;
          end
          token_count_len_next = len_inc;
          consumed             = 1'b1;
        end
      end
      stc_pkg::MODE_P_EQ, stc_pkg::MODE_P_BANG, stc_pkg::MODE_P_LT,
      stc_pkg::MODE_P_GT: begin
        p_valid        = 1'b1;
        scan_mode_next = stc_pkg::MODE_IDLE;
        if (!is_end && char_byte == "=") begin
          case (scan_mode)
            stc_pkg::MODE_P_EQ:   one_kind = stc_pkg::K_EQEQ;
            stc_pkg::MODE_P_BANG: one_kind = stc_pkg::K_BANGEQ;
            stc_pkg::MODE_P_LT:   one_kind = stc_pkg::K_LTE;
            default:              one_kind = stc_pkg::K_GTE;
          endcase
          p_tok    = stc_pkg::make_token(one_kind, stc_pkg::ERR_NONE,
                       tstart_ext[31:0], 16'd2, line_count, '0);
          consumed = 1'b1;
        end else if (scan_mode == stc_pkg::MODE_P_BANG) begin
          p_tok = stc_pkg::make_token(stc_pkg::K_ERROR, stc_pkg::ERR_BANG,
                    tstart_ext[31:0], 16'd1, line_count, '0);
        end else begin
          case (scan_mode)
            stc_pkg::MODE_P_EQ: one_kind = stc_pkg::K_EQ;
            stc_pkg::MODE_P_LT: one_kind = stc_pkg::K_LT;
            default:            one_kind = stc_pkg::K_GT;
          endcase
          p_tok = stc_pkg::make_token(one_kind, stc_pkg::ERR_NONE,
                    tstart_ext[31:0], 16'd1, line_count, '0);
        end
      end
      default: begin
        scan_mode_next = stc_pkg::MODE_IDLE;
      end
    endcase

    if (!consumed) begin
      if (is_end) begin
        // emit end token and restart
        i_valid              = 1'b1;
        i_tok                = stc_pkg::make_token(stc_pkg::K_END, stc_pkg::ERR_NONE,
                                 pos_ext[31:0], 16'd0, line_count, '0);
        scan_mode_next       = stc_pkg::MODE_IDLE;
        token_start_next     = '0;
        token_count_len_next = '0;
        byte_position_next   = '0;
        line_count_next      = 24'd1;
        number_accum_next    = '0;
      end else if (char_byte == " " || char_byte == "\t" || char_byte == 8'h0D) begin
        scan_mode_next = scan_mode_next;
      end else if (char_byte == "\n") begin
        line_count_next = line_inc;
      end else if (char_byte == "#") begin
        scan_mode_next = stc_pkg::MODE_COMMENT;
      end else if (ch_letter) begin
        scan_mode_next       = stc_pkg::MODE_IDENT;
        token_start_next     = byte_position;
        token_count_len_next = 16'd1;
        kw_we                = 1'b1;
        kw_wpos              = 16'd0;
      end else if (ch_numeral) begin
        scan_mode_next       = stc_pkg::MODE_NUMBER;
        token_start_next     = byte_position;
        token_count_len_next = 16'd1;
        number_accum_next    = 63'(char_byte[3:0]);
      end else if (char_byte == "\"") begin
        scan_mode_next       = stc_pkg::MODE_STRING;
        token_start_next     = byte_position + POSITION_BITS'(1);
        token_count_len_next = 16'd0;
      end else if (char_byte == "=") begin
        scan_mode_next   = stc_pkg::MODE_P_EQ;
        token_start_next = byte_position;
      end else if (char_byte == "!") begin
        scan_mode_next   = stc_pkg::MODE_P_BANG;
        token_start_next = byte_position;
      end else if (char_byte == "<") begin
        scan_mode_next   = stc_pkg::MODE_P_LT;
        token_start_next = byte_position;
      end else if (char_byte == ">") begin
        scan_mode_next   = stc_pkg::MODE_P_GT;
        token_start_next = byte_position;
      end else begin
        case (char_byte)
          "(":     one_kind = stc_pkg::K_LPAREN;
          ")":     one_kind = stc_pkg::K_RPAREN;
          ",":     one_kind = stc_pkg::K_COMMA;
          ";":     one_kind = stc_pkg::K_SEMI;
          "+":     one_kind = stc_pkg::K_PLUS;
          "-":     one_kind = stc_pkg::K_MINUS;
          "*":     one_kind = stc_pkg::K_STAR;
          "%":     one_kind = stc_pkg::K_PERCENT;
          "/":     one_kind = stc_pkg::K_SLASH;
          default: one_kind = stc_pkg::K_ERROR;
        endcase
        i_valid = 1'b1;
        i_tok   = stc_pkg::make_token(one_kind,
                    (one_kind == stc_pkg::K_ERROR) ? stc_pkg::ERR_CHAR : stc_pkg::ERR_NONE,
                    pos_ext[31:0], 16'd1, line_count, '0);
      end
    end
  end

  always_comb begin
    res_count        = 2'(p_valid) + 2'(i_valid);
    res0             = p_valid ? p_tok : i_tok;
    res0.last_of_run = !(p_valid && i_valid);
    res1             = i_tok;
    res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= stc_pkg::MODE_IDLE;
      token_start     <= '0;
      token_count_len <= '0;
      byte_position   <= '0;
      line_count      <= 24'd1;
      number_accum    <= '0;
    end else if (commit) begin
      scan_mode       <= scan_mode_next;
      token_start     <= token_start_next;
      token_count_len <= token_count_len_next;
      byte_position   <= byte_position_next;
      line_count      <= line_count_next;
      number_accum    <= number_accum_next;
    end
  end

  for (genvar i = 0; i < KEYWORD_CHARS; i++) begin : g_kwsel
    assign kw_sel[i] = commit && kw_we && (kw_wpos == 16'(i));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (kw_sel[i]) begin
        keyword_chars[i] <= char_byte;
      end
    end
  end

  assign status.idle      = scan_mode == stc_pkg::MODE_IDLE;
  assign status.at_origin = (byte_position == '0) && (line_count == 24'd1);

endmodule

/* design/source_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// Source tokenizer core
// Byte-serial lexical tokenizer with keyword match and number conversion.
// ----------------------------------------------------------------------------
// The core takes one source byte per clock cycle and retires it in a single
// registered step: a byte sits in the input register while the scanner forms
// zero, one or two tokens, which enter a four-entry token queue. Tokens leave
// the queue one per cycle while the sink is ready, so a byte that closes a
// pending token and also forms one of its own (or ends the text) yields two
// tokens. The input stalls only while fewer than two queue entries are free.
// An end-of-text byte flushes any pending token, emits the end token and
// returns the core to its reset state, including offset zero and line one.
module source_tokenizer_core #(
  parameter int KEYWORD_CHARS = 9,
  parameter int POSITION_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  stc_text_if.sink     text,
  stc_token_if.source  tokens
);

  `include "assert_macros.svh"

  logic                  hold_valid;
  logic [7:0]            hold_byte;
  logic                  hold_end;
  logic                  step_fire;
  logic                  pop;
  logic [1:0]            res_count;
  logic [1:0]            push_count;
  stc_pkg::token_t       res0, res1, head;
  stc_pkg::fifo_status_t fq_status;
  stc_pkg::scan_status_t sc_status;

  assign step_fire  = hold_valid && fq_status.room;
  assign text.ready = !hold_valid || step_fire;
  assign push_count = step_fire ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      hold_valid <= 1'b1;
    end else if (step_fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      hold_byte <= text.char_byte;
      hold_end  <= text.end_of_input;
    end
  end

  stc_scanner #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scanner (
    .clk         (clk),
    .rst         (rst),
    .commit      (step_fire),
    .char_byte   (hold_byte),
    .end_of_input(hold_end),
    .res_count   (res_count),
    .res0        (res0),
    .res1        (res1),
    .status      (sc_status)
  );

  stc_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push0     (res0),
    .push1     (res1),
    .pop       (pop),
    .head      (head),
    .status    (fq_status)
  );

  assign tokens.valid        = fq_status.count != '0;
  assign pop                 = tokens.valid && tokens.ready;
  assign tokens.token_kind   = head.token_kind;
  assign tokens.error_kind   = head.error_kind;
  assign tokens.start_pos    = head.start_pos;
  assign tokens.token_length = head.token_length;
  assign tokens.line_number  = head.line_number;
  assign tokens.number_value = head.number_value;
  assign tokens.last_of_run  = head.last_of_run;

  `STC_ASSERT(a_queue_bound, clk, rst,
    fq_status.count <= stc_pkg::FIFO_CNT_W'(stc_pkg::FIFO_DEPTH))
  `STC_ASSERT(a_pair_queued, clk, rst,
    !(tokens.valid && !tokens.last_of_run) || (fq_status.count >= stc_pkg::FIFO_CNT_W'(2)))
  `STC_ASSERT_NEXT(a_end_restart, clk, rst,
    step_fire && (hold_end || hold_byte == 8'h00),
    sc_status.idle && sc_status.at_origin)

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Streams source bytes into the tokenizer with random gaps, predicts every
// token in a cycle-free scanner model, and checks each token transfer field
// by field. Directed tests cover operators, keywords, numbers, end-of-text
// flushes and long tokens; a random test sends mostly well-formed text.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW_LIMIT = 9;
  localparam int RANDOM_ITEMS = 220;
  localparam int LONG_RUN = 20;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [62:0] NUM_MAX = {63{1'b1}};
  localparam string WORD_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
  localparam string OPS = "()=,;/+-*%!<>";
  localparam string BLANKS = " \t\015\n";
  localparam string SEPARATORS = " \n\t\015(;,";

  logic clk = 1'b0;
  logic rst = 1'b1;

  stc_text_if text_ch();
  stc_token_if token_ch();

  source_tokenizer_core dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (token_ch)
  );

  always #2 clk = ~clk;

  stc_pkg::scan_mode_t mode;
  logic [31:0] tok_start;
  logic [31:0] offset;
  logic [15:0] tok_len;
  logic [23:0] line_no;
  logic [62:0] accum;
  logic [7:0]  kw_buf [KW_LIMIT];

  stc_pkg::token_t pending_tokens[$];
  stc_pkg::token_t step_tokens[$];

  bit send_idle;
  bit sink_idle;
  int sink_hold;
  int bytes_sent;
  int tokens_checked;
  int mismatches;
  int cycle_count;
  bit kinds_seen [64];

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] len_step(logic [15:0] l);
    return (l == stc_pkg::LEN_MAX) ? l : l + 16'd1;
  endfunction

  function automatic void clear_state();
    mode = stc_pkg::MODE_IDLE;
    tok_start = '0;
    tok_len = '0;
    offset = '0;
    line_no = 24'd1;
    accum = '0;
    foreach (kw_buf[i]) kw_buf[i] = 8'h00;
  endfunction

  function automatic void emit(logic [5:0] kind, logic [1:0] err, logic [31:0] start,
                               logic [15:0] len, logic [62:0] value);
    step_tokens.push_back(stc_pkg::token_t'{kind, err, start, len, line_no, value, 1'b0});
  endfunction

  function automatic logic [5:0] word_kind();
    logic [5:0] kind;
    logic hit;
    kind = stc_pkg::K_IDENT;
    for (int i = 0; i < stc_pkg::KW_COUNT; i++) begin
      hit = (tok_len == 16'(stc_pkg::KW_LEN[i]));
      for (int j = 0; j < stc_pkg::KW_MAX_LEN; j++) begin
        if (hit && j < stc_pkg::KW_LEN[i] &&
            kw_buf[j] != stc_pkg::KW_TEXT[i][8*(stc_pkg::KW_LEN[i]-1-j) +: 8]) hit = 1'b0;
      end
      if (hit) kind = stc_pkg::KW_KIND[i];
    end
    return kind;
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic eoi);
    logic stop;
    logic taken;
    logic [31:0] here;
    logic [63:0] digit;
    stop = eoi || c == 8'h00;
    here = offset;
    taken = 1'b0;
    step_tokens.delete();
    case (mode)
      stc_pkg::MODE_COMMENT: begin
        if (!stop && c != 8'h0A) taken = 1'b1;
        else mode = stc_pkg::MODE_IDLE;
      end
      stc_pkg::MODE_IDENT: begin
        if (!stop && (is_letter(c) || is_numeral(c))) begin
          if (tok_len < KW_LIMIT) kw_buf[tok_len] = c;
          tok_len = len_step(tok_len);
          taken = 1'b1;
        end else begin
          emit(word_kind(), stc_pkg::ERR_NONE, tok_start, tok_len, '0);
          mode = stc_pkg::MODE_IDLE;
        end
      end
      stc_pkg::MODE_NUMBER: begin
        if (!stop && is_numeral(c)) begin
          digit = {56'd0, c - 8'h30};
          if ({1'b0, accum} > ({1'b0, NUM_MAX} - digit) / 64'd10) accum = NUM_MAX;
          else accum = 63'({1'b0, accum} * 64'd10 + digit);
          tok_len = len_step(tok_len);
          taken = 1'b1;
        end else begin
          emit(stc_pkg::K_NUMBER, stc_pkg::ERR_NONE, tok_start, tok_len, accum);
          mode = stc_pkg::MODE_IDLE;
        end
      end
      stc_pkg::MODE_STRING: begin
        if (stop) begin
          emit(stc_pkg::K_ERROR, stc_pkg::ERR_UNTERM, tok_start, tok_len, '0);
          mode = stc_pkg::MODE_IDLE;
        end else if (c == 8'h22) begin
          emit(stc_pkg::K_STRING, stc_pkg::ERR_NONE, tok_start, tok_len, '0);
          mode = stc_pkg::MODE_IDLE;
          taken = 1'b1;
        end else begin
          if (c == 8'h0A && line_no != stc_pkg::LINE_MAX) line_no++;
          tok_len = len_step(tok_len);
          taken = 1'b1;
        end
      end
      stc_pkg::MODE_P_EQ, stc_pkg::MODE_P_BANG, stc_pkg::MODE_P_LT,
      stc_pkg::MODE_P_GT: begin
        if (!stop && c == "=") begin
          emit(mode == stc_pkg::MODE_P_EQ ? stc_pkg::K_EQEQ :
               mode == stc_pkg::MODE_P_BANG ? stc_pkg::K_BANGEQ :
               mode == stc_pkg::MODE_P_LT ? stc_pkg::K_LTE : stc_pkg::K_GTE,
               stc_pkg::ERR_NONE, tok_start, 16'd2, '0);
          taken = 1'b1;
        end else if (mode == stc_pkg::MODE_P_BANG) begin
          emit(stc_pkg::K_ERROR, stc_pkg::ERR_BANG, tok_start, 16'd1, '0);
        end else begin
          emit(mode == stc_pkg::MODE_P_EQ ? stc_pkg::K_EQ :
               mode == stc_pkg::MODE_P_LT ? stc_pkg::K_LT : stc_pkg::K_GT,
               stc_pkg::ERR_NONE, tok_start, 16'd1, '0);
        end
        mode = stc_pkg::MODE_IDLE;
      end
      default: mode = stc_pkg::MODE_IDLE;
    endcase

    if (!taken && stop) begin
      emit(stc_pkg::K_END, stc_pkg::ERR_NONE, here, 16'd0, '0);
      clear_state();
    end else begin
      if (!taken) begin
        case (c)
          " ", 8'h09, 8'h0D: ;
          8'h0A: begin
            if (line_no != stc_pkg::LINE_MAX) line_no++;
          end
          "#": mode = stc_pkg::MODE_COMMENT;
          8'h22: begin
            mode = stc_pkg::MODE_STRING;
            tok_start = here + 32'd1;
            tok_len = '0;
          end
          "=": begin
            mode = stc_pkg::MODE_P_EQ;
            tok_start = here;
          end
          "!": begin
            mode = stc_pkg::MODE_P_BANG;
            tok_start = here;
          end
          "<": begin
            mode = stc_pkg::MODE_P_LT;
            tok_start = here;
          end
          ">": begin
            mode = stc_pkg::MODE_P_GT;
            tok_start = here;
          end
          "(": emit(stc_pkg::K_LPAREN, stc_pkg::ERR_NONE, here, 16'd1, '0);
          ")": emit(stc_pkg::K_RPAREN, stc_pkg::ERR_NONE, here, 16'd1, '0);
          ",": emit(stc_pkg::K_COMMA, stc_pkg::ERR_NONE, here, 16'd1, '0);
          ";": emit(stc_pkg::K_SEMI, stc_pkg::ERR_NONE, here, 16'd1, '0);
          "+": emit(stc_pkg::K_PLUS, stc_pkg::ERR_NONE, here, 16'd1, '0);
          "-": emit(stc_pkg::K_MINUS, stc_pkg::ERR_NONE, here, 16'd1, '0);
          "*": emit(stc_pkg::K_STAR, stc_pkg::ERR_NONE, here, 16'd1, '0);
          "%": emit(stc_pkg::K_PERCENT, stc_pkg::ERR_NONE, here, 16'd1, '0);
          "/": emit(stc_pkg::K_SLASH, stc_pkg::ERR_NONE, here, 16'd1, '0);
          default: begin
            if (is_letter(c)) begin
              mode = stc_pkg::MODE_IDENT;
              tok_start = here;
              tok_len = 16'd1;
              kw_buf[0] = c;
            end else if (is_numeral(c)) begin
              mode = stc_pkg::MODE_NUMBER;
              tok_start = here;
              tok_len = 16'd1;
              accum = {55'd0, c - 8'h30};
            end else begin
              emit(stc_pkg::K_ERROR, stc_pkg::ERR_CHAR, here, 16'd1, '0);
            end
          end
        endcase
      end
      offset = here + 32'd1;
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    stc_pkg::token_t want;
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) scan_byte(text_ch.char_byte, text_ch.end_of_input);
      if (token_ch.valid && token_ch.ready) begin
        tokens_checked++;
        kinds_seen[token_ch.token_kind] = 1'b1;
        if (pending_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: token expected none actual kind %0d at %0d", $time,
                   token_ch.token_kind, token_ch.start_pos);
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", 64'(want.token_kind), 64'(token_ch.token_kind));
          check_field("error_kind", 64'(want.error_kind), 64'(token_ch.error_kind));
          check_field("start_pos", 64'(want.start_pos), 64'(token_ch.start_pos));
          check_field("token_length", 64'(want.token_length), 64'(token_ch.token_length));
          check_field("line_number", 64'(want.line_number), 64'(token_ch.line_number));
          check_field("number_value", 64'(want.number_value), 64'(token_ch.number_value));
          check_field("last_of_run", 64'(want.last_of_run), 64'(token_ch.last_of_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      token_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (token_ch.valid && token_ch.ready && sink_idle) sink_hold = $urandom_range(0, 9);
      if (sink_hold > 0) begin
        token_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        token_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic eoi);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.char_byte <= c;
    text_ch.end_of_input <= eoi;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_repeat(logic [7:0] c, int n);
    repeat (n) send_byte(c, 1'b0);
  endtask

  function automatic logic [7:0] word_char(bit first);
    return WORD_CHARS[first ? $urandom_range(0, 52) : $urandom_range(0, 62)];
  endfunction

  task automatic test_operators();
    send_idle = 1'b1;
    sink_idle = 1'b1;
    send_text("=(),;/+-*%==!!=<<=>>=");
    send_text("\t\015\n#c\n@");
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_keywords();
    send_text("start module modul lib print var func return end if else while for to ");
    send_text("and or not input_");
    send_text("int input_in input_");
    send_text("intx modulex Start _if if9 asm");
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_numbers();
    send_text("0 9223372036854775807 9223372036854775808 99999999999999999999 007");
    send_byte("5", 1'b1);
  endtask

  task automatic test_end_flush();
    send_text("abc");
    send_byte(8'h00, 1'b0);
    send_text("\"ab\ncd");
    send_byte(8'($urandom), 1'b1);
    send_text("x #tail");
    send_byte(8'h00, 1'b0);
    send_text("=");
    send_byte(8'h00, 1'b0);
    send_text("!");
    send_byte(8'($urandom), 1'b1);
    send_text("\"\" >");
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_long_tokens();
    send_idle = 1'b0;
    sink_idle = 1'b0;
    send_byte("x", 1'b0);
    send_repeat("a", LONG_RUN);
    send_byte(" ", 1'b0);
    send_byte(8'h22, 1'b0);
    send_repeat("b", LONG_RUN);
    send_byte(8'h22, 1'b0);
    send_repeat("7", LONG_RUN);
    send_byte(";", 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_random_text();
    int first;
    int len;
    int k;
    logic [7:0] b;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          k = $urandom_range(0, stc_pkg::KW_COUNT - 1);
          len = int'(stc_pkg::KW_LEN[k]);
          if ($urandom_range(0, 3) == 0) len--;
          for (int j = 0; j < len; j++)
            send_byte(stc_pkg::KW_TEXT[k][8*(stc_pkg::KW_LEN[k]-1-j) +: 8], 1'b0);
          if ($urandom_range(0, 3) == 0) send_byte(word_char(1'b0), 1'b0);
          send_byte(SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)], 1'b0);
        end
        3, 4: begin
          len = $urandom_range(1, 12);
          send_byte(word_char(1'b1), 1'b0);
          repeat (len - 1) send_byte(word_char(1'b0), 1'b0);
          send_byte(SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)], 1'b0);
        end
        5, 6: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 22) : $urandom_range(1, 6);
          repeat (len) send_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
          send_byte(SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)], 1'b0);
        end
        7: begin
          send_byte(8'h22, 1'b0);
          repeat ($urandom_range(0, 10)) begin
            b = ($urandom_range(0, 5) == 0) ? 8'h0A : 8'($urandom_range(1, 255));
            if (b == 8'h22) b = "q";
            send_byte(b, 1'b0);
          end
          if ($urandom_range(0, 9) != 0) send_byte(8'h22, 1'b0);
        end
        8, 9, 10, 11: begin
          send_byte(OPS[$urandom_range(0, OPS.len() - 1)], 1'b0);
          if ($urandom_range(0, 2) == 0) send_byte("=", 1'b0);
        end
        12, 13: send_byte(BLANKS[$urandom_range(0, BLANKS.len() - 1)], 1'b0);
        14: begin
          send_byte("#", 1'b0);
          repeat ($urandom_range(0, 8)) begin
            b = 8'($urandom_range(1, 255));
            if (b == 8'h0A) b = "x";
            send_byte(b, 1'b0);
          end
          send_byte(8'h0A, 1'b0);
        end
        15: send_byte(8'($urandom_range(1, 255)), 1'b0);
        16: begin
          if ($urandom_range(0, 1) == 0) send_byte(8'h00, 1'b0);
          else send_byte(8'($urandom), 1'b1);
        end
        default: send_byte(" ", 1'b0);
      endcase
    end
    send_byte(8'h00, 1'b0);
  endtask

  initial begin
    int kinds;
    text_ch.valid = 1'b0;
    text_ch.char_byte = 8'h00;
    text_ch.end_of_input = 1'b0;
    token_ch.ready = 1'b0;
    clear_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operators();
    test_keywords();
    test_numbers();
    test_end_flush();
    test_long_tokens();
    test_random_text();

    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    kinds = 0;
    foreach (kinds_seen[i]) kinds += int'(kinds_seen[i]);
    $display("Checked %0d tokens from %0d source bytes, %0d of 40 token kinds seen",
             tokens_checked, bytes_sent, kinds);
    $display("Covered operators, keywords, number saturation, end-of-text flushes, long tokens and random text");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/stc_pkg.sv
design/stc_channels.sv
design/stc_result_fifo.sv
design/stc_scanner.sv
design/source_tokenizer_core.sv
dv/tb.sv
